// ===== rtl/lgs_pkg.sv =====
// lgs_pkg: shared constants, command codes, state codes and the
// control/status structs of the life grid stepper.
// No dependencies; every rtl file imports it.
package lgs_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int DIM_W = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
   localparam int CNT_W = $clog2(MAX_ROWS + 2);
   localparam int CFG_W = 7;
   localparam int IDX_W = 2;
   localparam int GEN_W = 32;
   localparam int CMD_W = 2;
   localparam int NBR_W = 4;

   localparam logic [IDX_W-1:0] REG_GRID_ROWS = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_GRID_COLS = IDX_W'(1);

   typedef enum logic [CMD_W-1:0] {
      OP_WRITE = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } lgs_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_STEP,
      ST_DRAIN,
      ST_FINISH
   } lgs_state_type;

   typedef struct packed {
      logic             latch_req;
      logic             cell_wr;
      logic [ROW_W-1:0] rd_row;
      logic             shift;
      logic             row_wr;
      logic [ROW_W-1:0] wr_row;
      logic             cell_cap;
      logic             step_done;
      logic             load_rsp;
   } lgs_cmd_type;

   typedef struct packed {
      lgs_op_type       op;
      logic             err;
      logic [ROW_W-1:0] req_row;
      logic [DIM_W-1:0] rows;
   } lgs_status_type;

endpackage

// ===== rtl/lgs_ctrl.sv =====
// lgs_ctrl: sequencer of the life grid stepper. Runs the handshakes,
// decodes each word and sweeps the rows during a step. Uses lgs_pkg.
module lgs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  lgs_pkg::lgs_status_type status,
   output lgs_pkg::lgs_cmd_type    cmd
);
   import lgs_pkg::*;

   lgs_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [ROW_W-1:0] wr_row_ff, wr_row_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] last_cnt;

   assign last_cnt  = CNT_W'(status.rows) + CNT_W'(1);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         wr_row_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wr_pend_ff   <= wr_pend_in;
         wr_row_ff    <= wr_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      wr_pend_in    = 1'b0;
      wr_row_in     = wr_row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      cmd.row_wr    = wr_pend_ff;
      cmd.wr_row    = wr_row_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               OP_WRITE: begin
                  cmd.cell_wr = !status.err;
                  state_in    = ST_FINISH;
               end
               OP_READ: begin
                  cmd.rd_row = status.req_row;
                  state_in   = status.err ? ST_FINISH : ST_READ;
               end
               OP_STEP: begin
                  cnt_in   = '0;
                  state_in = ST_STEP;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_READ: begin
            cmd.cell_cap = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_STEP: begin
            // read order: last row, rows 0 .. last, then row 0 again
            cmd.shift = 1'b1;
            if (cnt_ff == '0) begin
               cmd.rd_row = ROW_W'(status.rows - DIM_W'(1));
            end else if (cnt_ff == last_cnt) begin
               cmd.rd_row = '0;
            end else begin
               cmd.rd_row = ROW_W'(cnt_ff - CNT_W'(1));
            end
            // window is full from the third read on; write one row behind
            wr_pend_in = (cnt_ff >= CNT_W'(2));
            wr_row_in  = ROW_W'(cnt_ff - CNT_W'(2));
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == last_cnt) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.step_done = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/lgs_datapath.sv =====
// lgs_datapath: the two grid buffers, the three-row neighbor window,
// the row-wide next-generation logic, config and result registers.
// Uses lgs_pkg; driven by lgs_ctrl.
module lgs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [lgs_pkg::CMD_W-1:0] req_cmd,
   input  logic [lgs_pkg::ROW_W-1:0] req_row,
   input  logic [lgs_pkg::COL_W-1:0] req_col,
   input  logic                   req_alive_in,
   input  logic                   csr_write,
   input  logic [lgs_pkg::IDX_W-1:0] csr_index,
   input  logic [lgs_pkg::CFG_W-1:0] csr_wdata,
   input  lgs_pkg::lgs_cmd_type    cmd,
   output lgs_pkg::lgs_status_type status,
   output logic                   rsp_cell_alive,
   output logic [lgs_pkg::GEN_W-1:0] rsp_generation,
   output logic                   rsp_error
);
   import lgs_pkg::*;

   localparam logic [NBR_W-1:0] BIRTH_COUNT = NBR_W'(3);
   localparam logic [NBR_W-1:0] STAY_COUNT  = NBR_W'(2);

   logic [MAX_COLS-1:0] mem_a [MAX_ROWS];
   logic [MAX_COLS-1:0] mem_b [MAX_ROWS];
   logic [MAX_COLS-1:0] rd_a_ff, rd_b_ff, rd_q;
   logic [MAX_COLS-1:0] above_ff, mid_ff;

   logic                which_ff;
   logic [GEN_W-1:0]    gen_ff;
   logic [DIM_W-1:0]    rows_ff, cols_ff;

   lgs_op_type          op_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [COL_W-1:0]    col_ff;
   logic                alive_ff;
   logic                cell_ff;
   logic                err;

   logic                wr_a, wr_b;
   logic [ROW_W-1:0]    wr_addr;
   logic [MAX_COLS-1:0] wr_mask, wr_data;
   logic [MAX_COLS-1:0] col_mask, next_row;
   logic [COL_W-1:0]    last_col;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input int maxv);
      logic [DIM_W-1:0] r;
      r = DIM_W'(v);
      if (r == '0) begin
         r = DIM_W'(1);
      end else if (r > DIM_W'(maxv)) begin
         r = DIM_W'(maxv);
      end
      return r;
   endfunction

   assign err = ((op_ff == OP_WRITE) || (op_ff == OP_READ)) &&
                ((DIM_W'(row_ff) >= rows_ff) || (DIM_W'(col_ff) >= cols_ff));

   assign status.op      = op_ff;
   assign status.err     = err;
   assign status.req_row = row_ff;
   assign status.rows    = rows_ff;

   assign rd_q     = which_ff ? rd_b_ff : rd_a_ff;
   assign last_col = COL_W'(cols_ff - DIM_W'(1));

   // next generation of the row in the middle of the window, columns wrap
   always_comb begin
      logic [NBR_W-1:0] n;
      logic             l_up, l_md, l_dn, r_up, r_md, r_dn;
      for (int c = 0; c < MAX_COLS; c++) begin
         if (c == 0) begin
            l_up = above_ff[last_col];
            l_md = mid_ff[last_col];
            l_dn = rd_q[last_col];
         end else begin
            l_up = above_ff[c-1];
            l_md = mid_ff[c-1];
            l_dn = rd_q[c-1];
         end
         if (c == MAX_COLS - 1 || COL_W'(c) == last_col) begin
            r_up = above_ff[0];
            r_md = mid_ff[0];
            r_dn = rd_q[0];
         end else begin
            r_up = above_ff[c+1];
            r_md = mid_ff[c+1];
            r_dn = rd_q[c+1];
         end
         n = NBR_W'(l_up) + NBR_W'(above_ff[c]) + NBR_W'(r_up) + NBR_W'(l_md) +
             NBR_W'(r_md) + NBR_W'(l_dn) + NBR_W'(rd_q[c]) + NBR_W'(r_dn);
         next_row[c] = (n == BIRTH_COUNT) || (mid_ff[c] && (n == STAY_COUNT));
         col_mask[c] = (DIM_W'(c) < cols_ff);
      end
   end

   // cell writes hit the live buffer, step rows the other one
   always_comb begin
      wr_a    = 1'b0;
      wr_b    = 1'b0;
      wr_addr = cmd.wr_row;
      wr_mask = '0;
      wr_data = next_row;
      if (cmd.cell_wr) begin
         wr_addr          = row_ff;
         wr_mask[col_ff]  = 1'b1;
         wr_data          = {MAX_COLS{alive_ff}};
         wr_a             = !which_ff;
         wr_b             = which_ff;
      end else if (cmd.row_wr) begin
         wr_mask = col_mask;
         wr_a    = which_ff;
         wr_b    = !which_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < MAX_COLS; b++) begin
         if (wr_a && wr_mask[b]) begin
            mem_a[wr_addr][b] <= wr_data[b];
         end
         if (wr_b && wr_mask[b]) begin
            mem_b[wr_addr][b] <= wr_data[b];
         end
      end
      rd_a_ff <= mem_a[cmd.rd_row];
      rd_b_ff <= mem_b[cmd.rd_row];
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         above_ff <= mid_ff;
         mid_ff   <= rd_q;
      end
      if (cmd.latch_req) begin
         op_ff    <= lgs_op_type'(req_cmd);
         row_ff   <= req_row;
         col_ff   <= req_col;
         alive_ff <= req_alive_in;
         cell_ff  <= 1'b0;
      end else if (cmd.cell_cap) begin
         cell_ff <= rd_q[col_ff] && !err;
      end
      if (cmd.load_rsp) begin
         rsp_cell_alive <= cell_ff;
         rsp_generation <= gen_ff;
         rsp_error      <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         which_ff <= 1'b0;
         gen_ff   <= '0;
         rows_ff  <= DIM_W'(MAX_ROWS);
         cols_ff  <= DIM_W'(MAX_COLS);
      end else begin
         if (cmd.step_done) begin
            which_ff <= !which_ff;
            gen_ff   <= gen_ff + GEN_W'(1);
         end
         if (csr_write && csr_index == REG_GRID_ROWS) begin
            rows_ff <= clamp_dim(csr_wdata, MAX_ROWS);
         end
         if (csr_write && csr_index == REG_GRID_COLS) begin
            cols_ff <= clamp_dim(csr_wdata, MAX_COLS);
         end
      end
   end

endmodule

// ===== rtl/life_grid_stepper.sv =====
// life_grid_stepper: toroidal Game of Life grid with cell write, cell read
// and single-generation step. Top level; uses lgs_pkg, lgs_ctrl, lgs_datapath.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_cmd, req_row, req_col, req_alive_in | in
//   rsp     | rsp_cell_alive, rsp_generation, rsp_error| out
//   csr     | csr_index, csr_wdata (csr_ready high)   | in
//
// One word at a time; a step sweeps the grid rows through the single read
// port of each buffer.
// Synchronous reset clears control and generation count, sets the full grid size;
// grid contents stay undefined until written, so there is no clearing pass.
// A waiting response is held in its output register while the next word is
// taken; that word completes once the response is consumed.
module life_grid_stepper (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lgs_pkg::CMD_W-1:0]   req_cmd,
   input  logic [lgs_pkg::ROW_W-1:0]   req_row,
   input  logic [lgs_pkg::COL_W-1:0]   req_col,
   input  logic                        req_alive_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_cell_alive,
   output logic [lgs_pkg::GEN_W-1:0]   rsp_generation,
   output logic                        rsp_error,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lgs_pkg::IDX_W-1:0]   csr_index,
   input  logic [lgs_pkg::CFG_W-1:0]   csr_wdata
);
   import lgs_pkg::*;

   lgs_cmd_type    cmd;
   lgs_status_type status;

   assign csr_ready = 1'b1;

   lgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lgs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_alive_in   (req_alive_in),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_cell_alive (rsp_cell_alive),
      .rsp_generation (rsp_generation),
      .rsp_error      (rsp_error)
   );

endmodule

// ===== rtl/lgs_checker.sv =====
// lgs_checker: port-level assertions for life_grid_stepper, attached by
// the bind at the end of this file. Uses lgs_pkg.
module lgs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_cell_alive,
   input logic [lgs_pkg::GEN_W-1:0] rsp_generation,
   input logic                      rsp_error
);
   import lgs_pkg::*;

   // one word in flight: no second accept right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted on consecutive cycles");

   // with no response waiting, an accepted word shows none while it is decoded
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared right after accept");

   // a flagged error never carries a read value
   a_err_no_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_cell_alive)
      else $error("error response with cell_alive set");

   // a stalled response holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_generation) &&
                                  $stable(rsp_error) && $stable(rsp_cell_alive))
      else $error("stalled response changed");

endmodule

bind life_grid_stepper lgs_checker u_lgs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cell_alive (rsp_cell_alive),
   .rsp_generation (rsp_generation),
   .rsp_error      (rsp_error)
);

// ===== tb/sv/tb_life_grid_stepper.sv =====
// tb_life_grid_stepper: self-checking bench for the toroidal life grid stepper.
// Drives cell writes, reads, steps and register writes, and predicts every response.
// Depends on lgs_pkg and life_grid_stepper.
`timescale 1ns / 1ps

module tb_life_grid_stepper;
   import lgs_pkg::*;

   localparam logic [IDX_W-1:0] REG_SPARE_2 = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_SPARE_3 = IDX_W'(3);
   localparam int PHASES = 9;
   localparam int PHASE_WORDS = 12;
   localparam int DIR_ROWS = 33;

   typedef struct packed {
      logic             live;
      logic [GEN_W-1:0] gen;
      logic             err;
   } cell_result_type;

   typedef enum logic {ROW_REQ, ROW_CFG} tbl_kind_type;

   typedef struct packed {
      tbl_kind_type     kind;
      lgs_op_type       op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             alive;
      logic [IDX_W-1:0] idx;
      logic [CFG_W-1:0] wdata;
      logic             typed;
      cell_result_type  want;
   } tbl_row_type;

   // Directed rows; typed expectations only where the answer is obvious.
   tbl_row_type directed_tbl [DIR_ROWS] = '{
      '{ROW_REQ, OP_NONE,  63, 63, 1, REG_GRID_ROWS,   0, 1, '{0, 0, 0}},
      '{ROW_REQ, OP_WRITE,  0,  0, 1, REG_GRID_ROWS,   0, 1, '{0, 0, 0}},
      '{ROW_REQ, OP_WRITE, 63, 63, 1, REG_GRID_ROWS,   0, 1, '{0, 0, 0}},
      '{ROW_REQ, OP_READ,  63, 63, 0, REG_GRID_ROWS,   0, 1, '{1, 0, 0}},
      '{ROW_REQ, OP_READ,   0,  0, 1, REG_GRID_ROWS,   0, 1, '{1, 0, 0}},
      '{ROW_CFG, OP_NONE,   0,  0, 0, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_CFG, OP_NONE,   0,  0, 0, REG_GRID_COLS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_READ,   1,  0, 0, REG_GRID_ROWS,   0, 1, '{0, 0, 1}},
      '{ROW_REQ, OP_WRITE,  0,  1, 1, REG_GRID_ROWS,   0, 1, '{0, 0, 1}},
      '{ROW_REQ, OP_READ,   0,  0, 0, REG_GRID_ROWS,   0, 1, '{1, 0, 0}},
      '{ROW_REQ, OP_STEP,   0,  0, 0, REG_GRID_ROWS,   0, 1, '{0, 1, 0}},
      '{ROW_REQ, OP_READ,   0,  0, 0, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_STEP,  42, 21, 1, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_READ,   0,  0, 0, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_CFG, OP_NONE,   0,  0, 0, REG_SPARE_2,     5, 0, '{0, 0, 0}},
      '{ROW_CFG, OP_NONE,   0,  0, 0, REG_SPARE_3,     9, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_READ,   0,  1, 0, REG_GRID_ROWS,   0, 1, '{0, 2, 1}},
      '{ROW_CFG, OP_NONE,   0,  0, 0, REG_GRID_ROWS, 127, 0, '{0, 0, 0}},
      '{ROW_CFG, OP_NONE,   0,  0, 0, REG_GRID_COLS, 100, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_READ,  63, 63, 0, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_CFG, OP_NONE,   0,  0, 0, REG_GRID_ROWS,   2, 0, '{0, 0, 0}},
      '{ROW_CFG, OP_NONE,   0,  0, 0, REG_GRID_COLS,   3, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_WRITE,  0,  0, 1, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_WRITE,  0,  1, 1, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_WRITE,  0,  2, 0, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_WRITE,  1,  0, 0, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_WRITE,  1,  1, 1, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_WRITE,  1,  2, 0, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_STEP,   0,  0, 0, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_READ,   1,  2, 0, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_READ,   0,  1, 0, REG_GRID_ROWS,   0, 0, '{0, 0, 0}},
      '{ROW_REQ, OP_WRITE,  2,  0, 1, REG_GRID_ROWS,   0, 1, '{0, 3, 1}},
      '{ROW_REQ, OP_READ,   0,  3, 0, REG_GRID_ROWS,   0, 1, '{0, 3, 1}}
   };

   int unsigned phase_rows_raw [7] = '{ 1, 64, 2, 3, 1, 5, 127};
   int unsigned phase_cols_raw [7] = '{64,  1, 2, 3, 1, 7,   0};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [ROW_W-1:0]    req_row = '0;
   logic [COL_W-1:0]    req_col = '0;
   logic                req_alive_in = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_cell_alive;
   logic [GEN_W-1:0]    rsp_generation;
   logic                rsp_error;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [IDX_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]    csr_wdata = '0;

   // predicted grid state and configuration
   logic [MAX_COLS-1:0] life_now  [MAX_ROWS];
   logic [MAX_COLS-1:0] life_next [MAX_ROWS];
   logic [GEN_W-1:0]    gen_count = '0;
   int                  rows_used = MAX_ROWS;
   int                  cols_used = MAX_COLS;

   cell_result_type     pending_results [$];
   int                  mismatches = 0;
   bit                  no_idle = 1'b0;

   life_grid_stepper u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_alive_in   (req_alive_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_alive (rsp_cell_alive),
      .rsp_generation (rsp_generation),
      .rsp_error      (rsp_error),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int clamp_dim(logic [CFG_W-1:0] value, int maxv);
      int d;
      d = value;
      if (d < 1) d = 1;
      if (d > maxv) d = maxv;
      return d;
   endfunction

   function automatic int count_live_neighbours(int r, int c);
      int up, dn, lf, rt;
      up = (r == 0) ? rows_used - 1 : r - 1;
      dn = (r + 1 >= rows_used) ? r + 1 - rows_used : r + 1;
      lf = (c == 0) ? cols_used - 1 : c - 1;
      rt = (c + 1 >= cols_used) ? c + 1 - cols_used : c + 1;
      // narrow grids may count the same cell more than once
      return int'(life_now[up][lf]) + int'(life_now[up][c]) + int'(life_now[up][rt])
           + int'(life_now[r][lf]) + int'(life_now[r][rt])
           + int'(life_now[dn][lf]) + int'(life_now[dn][c]) + int'(life_now[dn][rt]);
   endfunction

   function automatic void advance_generation();
      int n;
      logic [MAX_COLS-1:0] held;
      for (int r = 0; r < rows_used; r++) begin
         for (int c = 0; c < cols_used; c++) begin
            n = count_live_neighbours(r, c);
            life_next[r][c] = (n == 3) || (life_now[r][c] && n == 2);
         end
      end
      // swap whole buffers, cells outside the grid included
      for (int r = 0; r < MAX_ROWS; r++) begin
         held = life_now[r];
         life_now[r] = life_next[r];
         life_next[r] = held;
      end
      gen_count = gen_count + 1'b1;
   endfunction

   function automatic cell_result_type apply_word(lgs_op_type op, logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col, logic alive);
      cell_result_type res;
      res = '0;
      if (op == OP_WRITE || op == OP_READ) begin
         if (row >= rows_used || col >= cols_used) res.err = 1'b1;
         else if (op == OP_WRITE) life_now[row][col] = alive;
         else res.live = life_now[row][col];
      end else if (op == OP_STEP) begin
         advance_generation();
      end
      res.gen = gen_count;
      return res;
   endfunction

   function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_GRID_ROWS) rows_used = clamp_dim(value, MAX_ROWS);
      else if (idx == REG_GRID_COLS) cols_used = clamp_dim(value, MAX_COLS);
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Leaves req_valid high after the word is taken; the next call's idle cycles or a register write drop it.
   task automatic send_word(input lgs_op_type op, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic alive,
                            input logic typed, input cell_result_type want);
      cell_result_type predicted;
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 11) begin
            req_valid <= 1'b0;
            csr_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid    <= 1'b1;
      csr_valid    <= 1'b0;
      req_cmd      <= op;
      req_row      <= row;
      req_col      <= col;
      req_alive_in <= alive;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_word(op, row, col, alive);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Register writes go in only once every response has come back.
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, value);
   endtask

   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("response with nothing outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_cell_alive !== want.live)
               flag_mismatch($sformatf("cell_alive got %b want %b", rsp_cell_alive, want.live));
            if (rsp_generation !== want.gen)
               flag_mismatch($sformatf("generation got %0d want %0d",
                                       rsp_generation, want.gen));
            if (rsp_error !== want.err)
               flag_mismatch($sformatf("error got %b want %b", rsp_error, want.err));
         end
      end
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 11);
   end

   initial begin
      tbl_row_type  t;
      lgs_op_type   op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [CFG_W-1:0] raw_r, raw_c;
      int           pick;

      for (int r = 0; r < MAX_ROWS; r++) begin
         life_now[r]  = '0;
         life_next[r] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         t = directed_tbl[i];
         if (t.kind == ROW_CFG) write_reg(t.idx, t.wdata);
         else send_word(t.op, t.row, t.col, t.alive, t.typed, t.want);
      end

      for (int p = 0; p < PHASES; p++) begin
         raw_r = (p < 7) ? CFG_W'(phase_rows_raw[p]) : CFG_W'($urandom_range(0, 8));
         raw_c = (p < 7) ? CFG_W'(phase_cols_raw[p]) : CFG_W'($urandom_range(0, 8));
         if ($urandom_range(0, 1)) begin
            write_reg(REG_GRID_ROWS, raw_r);
            write_reg(REG_GRID_COLS, raw_c);
         end else begin
            write_reg(REG_GRID_COLS, raw_c);
            write_reg(REG_GRID_ROWS, raw_r);
         end
         write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
         no_idle = (p == 1);
         // refill the live grid so every cell a step or read touches is written
         for (int r = 0; r < rows_used; r++) begin
            for (int c = 0; c < cols_used; c++)
               send_word(OP_WRITE, ROW_W'(r), COL_W'(c), $urandom_range(0, 99) < 35,
                         1'b0, '0);
         end
         for (int i = 0; i < PHASE_WORDS; i++) begin
            pick = $urandom_range(0, 99);
            row  = ROW_W'($urandom);
            col  = COL_W'($urandom);
            if (pick < 5) begin
               op = OP_NONE;
            end else if (pick < 18) begin
               op = OP_STEP;
            end else begin
               op  = (pick < 58 || (pick >= 92 && pick[0])) ? OP_WRITE : OP_READ;
               row = ROW_W'($urandom_range(0, rows_used - 1));
               col = COL_W'($urandom_range(0, cols_used - 1));
               // push row or column past the grid edge where the grid allows it
               if (pick >= 92) begin
                  if (rows_used < MAX_ROWS && ($urandom_range(0, 1) || cols_used == MAX_COLS))
                     row = ROW_W'($urandom_range(rows_used, MAX_ROWS - 1));
                  else if (cols_used < MAX_COLS)
                     col = COL_W'($urandom_range(cols_used, MAX_COLS - 1));
               end
            end
            send_word(op, row, col, 1'($urandom), 1'b0, '0);
         end
      end
      no_idle = 1'b0;

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lgs_pkg.sv
rtl/lgs_ctrl.sv
rtl/lgs_datapath.sv
rtl/life_grid_stepper.sv
rtl/lgs_checker.sv
tb/sv/tb_life_grid_stepper.sv
